>>> rtl/mmss_pkg.sv
// Shared types and constants for the max-min spacing search block.
package mmss_pkg;

  localparam int POS_W = 30;
  localparam int PC_W  = 11;
  localparam logic [PC_W-1:0] PC_RESET = 11'd2;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_CLEAR,
    OP_SORT_SEL,
    OP_SORT_V,
    OP_SORT_RDJ,
    OP_SORT_SHIFT,
    OP_SORT_INS,
    OP_SPAN_RD0,
    OP_SPAN_RDN,
    OP_SPAN_SET,
    OP_TRIAL,
    OP_SCAN_RD,
    OP_SCAN_CHK,
    OP_EVAL
  } op_t;

  typedef struct packed {
    op_t  op;
  } cmd_t;

  typedef struct packed {
    logic i_done;
    logic gt;
    logic j_one;
    logic k_done;
    logic empty;
    logic feasible;
  } stat_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_SORT_I,
    ST_SORT_V,
    ST_SORT_J,
    ST_SORT_C,
    ST_SORT_P,
    ST_SPAN0,
    ST_SPAN1,
    ST_SPAN2,
    ST_TRIAL,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_EVAL,
    ST_DONE
  } state_t;

endpackage

>>> rtl/mmss_in_if.sv
// Input channel: one point position per beat.
interface mmss_in_if;
  import mmss_pkg::*;
  logic             valid;
  logic             ready;
  logic [POS_W-1:0] position;
  logic             last;
  modport source (output valid, output position, output last, input ready);
  modport sink   (input valid, input position, input last, output ready);
endinterface

>>> rtl/mmss_out_if.sv
// Result channel: best gap and overflow flag per beat.
interface mmss_out_if;
  import mmss_pkg::*;
  logic             valid;
  logic             ready;
  logic [POS_W-1:0] best_gap;
  logic             overflow;
  modport source (output valid, output best_gap, output overflow, input ready);
  modport sink   (input valid, input best_gap, input overflow, output ready);
endinterface

>>> rtl/mmss_ram.sv
// Generic single write, single read RAM with registered read data.
module mmss_ram #(
  parameter int WIDTH = 30,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> rtl/mmss_dp.sv
// Datapath: point store, insertion sort, greedy scan and binary search registers.
module mmss_dp #(
  parameter int MAX_POINTS = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mmss_pkg::cmd_t                cmd,
  output mmss_pkg::stat_t               stat,
  input  logic [mmss_pkg::POS_W-1:0]    position,
  input  logic                          cfg_we,
  input  logic [mmss_pkg::PC_W-1:0]     cfg_wdata,
  output logic [mmss_pkg::POS_W-1:0]    best_gap,
  output logic                          overflow
);
  import mmss_pkg::*;

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int PW = (CW > PC_W) ? CW : PC_W;
  localparam logic [CW-1:0] MAXC = CW'(MAX_POINTS);
  localparam logic [CW-1:0] ONEC = CW'(1);

  logic [CW-1:0]    cnt_r, i_r, k_r, placed_r;
  logic [AW-1:0]    j_r;
  logic             ovf_r;
  logic [POS_W-1:0] v_r, first_r, hi_r, mid_r, best_r, prev_r;
  logic [POS_W:0]   lo_r;
  logic [PC_W-1:0]  pc_r;

  logic             we;
  logic [AW-1:0]    waddr, raddr;
  logic [POS_W-1:0] wdata, rdata;
  logic [POS_W:0]   mid_sum;
  logic [POS_W-1:0] diff;

  mmss_ram #(.WIDTH(POS_W), .DEPTH(MAX_POINTS)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign mid_sum = {1'b0, hi_r} + lo_r;
  assign diff    = rdata - prev_r;

  always_comb begin
    we    = 1'b0;
    waddr = j_r;
    wdata = v_r;
    raddr = '0;
    unique case (cmd.op)
      OP_LOAD: begin
        we    = (cnt_r < MAXC);
        waddr = cnt_r[AW-1:0];
        wdata = position;
      end
      OP_SORT_SEL:   raddr = i_r[AW-1:0];
      OP_SORT_RDJ:   raddr = j_r - AW'(1);
      OP_SORT_SHIFT: begin
        we    = 1'b1;
        wdata = rdata;
      end
      OP_SORT_INS:   we = 1'b1;
      OP_SPAN_RDN:   raddr = AW'(cnt_r - ONEC);
      OP_SCAN_RD:    raddr = k_r[AW-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      ovf_r <= 1'b0;
      pc_r  <= PC_RESET;
    end else begin
      if (cfg_we) begin
        pc_r <= cfg_wdata;
      end
      unique case (cmd.op)
        OP_LOAD: begin
          i_r <= ONEC;
          if (cnt_r < MAXC) begin
            cnt_r <= cnt_r + ONEC;
          end else begin
            ovf_r <= 1'b1;
          end
        end
        OP_CLEAR: begin
          cnt_r <= '0;
          ovf_r <= 1'b0;
        end
        OP_SORT_SEL:   j_r <= i_r[AW-1:0];
        OP_SORT_V:     v_r <= rdata;
        OP_SORT_SHIFT: j_r <= j_r - AW'(1);
        OP_SORT_INS:   i_r <= i_r + ONEC;
        OP_SPAN_RDN:   first_r <= rdata;
        OP_SPAN_SET: begin
          hi_r   <= rdata - first_r;
          lo_r   <= (POS_W+1)'(1);
          best_r <= '0;
        end
        OP_TRIAL: begin
          mid_r    <= mid_sum[POS_W:1];
          placed_r <= ONEC;
          prev_r   <= first_r;
          k_r      <= ONEC;
        end
        OP_SCAN_CHK: begin
          if (diff >= mid_r) begin
            placed_r <= placed_r + ONEC;
            prev_r   <= rdata;
          end
          k_r <= k_r + ONEC;
        end
        OP_EVAL: begin
          if (stat.feasible) begin
            best_r <= mid_r;
            lo_r   <= {1'b0, mid_r} + (POS_W+1)'(1);
          end else begin
            hi_r <= mid_r - POS_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  assign stat.i_done   = (i_r >= cnt_r);
  assign stat.gt       = (rdata > v_r);
  assign stat.j_one    = (j_r == AW'(1));
  assign stat.k_done   = (k_r >= cnt_r);
  assign stat.empty    = (lo_r > {1'b0, hi_r});
  assign stat.feasible = (PW'(placed_r) >= PW'(pc_r));

  assign best_gap = best_r;
  assign overflow = ovf_r;
endmodule

>>> rtl/mmss_ctrl.sv
// Controller: sequences load, sort, span setup and the binary search.
module mmss_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_last,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  mmss_pkg::stat_t stat,
  output mmss_pkg::cmd_t  cmd
);
  import mmss_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NONE;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      ST_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op = OP_LOAD;
          if (in_last) state_nxt = ST_SORT_I;
        end
      end
      ST_SORT_I: begin
        if (stat.i_done) begin
          state_nxt = ST_SPAN0;
        end else begin
          cmd.op    = OP_SORT_SEL;
          state_nxt = ST_SORT_V;
        end
      end
      ST_SORT_V: begin
        cmd.op    = OP_SORT_V;
        state_nxt = ST_SORT_J;
      end
      ST_SORT_J: begin
        cmd.op    = OP_SORT_RDJ;
        state_nxt = ST_SORT_C;
      end
      ST_SORT_C: begin
        if (stat.gt) begin
          cmd.op    = OP_SORT_SHIFT;
          state_nxt = stat.j_one ? ST_SORT_P : ST_SORT_J;
        end else begin
          cmd.op    = OP_SORT_INS;
          state_nxt = ST_SORT_I;
        end
      end
      ST_SORT_P: begin
        cmd.op    = OP_SORT_INS;
        state_nxt = ST_SORT_I;
      end
      ST_SPAN0: begin
        cmd.op    = OP_SPAN_RD0;
        state_nxt = ST_SPAN1;
      end
      ST_SPAN1: begin
        cmd.op    = OP_SPAN_RDN;
        state_nxt = ST_SPAN2;
      end
      ST_SPAN2: begin
        cmd.op    = OP_SPAN_SET;
        state_nxt = ST_TRIAL;
      end
      ST_TRIAL: begin
        if (stat.empty) begin
          state_nxt = ST_DONE;
        end else begin
          cmd.op    = OP_TRIAL;
          state_nxt = ST_SCAN_RD;
        end
      end
      ST_SCAN_RD: begin
        if (stat.k_done) begin
          state_nxt = ST_EVAL;
        end else begin
          cmd.op    = OP_SCAN_RD;
          state_nxt = ST_SCAN_CHK;
        end
      end
      ST_SCAN_CHK: begin
        cmd.op    = OP_SCAN_CHK;
        state_nxt = ST_SCAN_RD;
      end
      ST_EVAL: begin
        cmd.op    = OP_EVAL;
        state_nxt = ST_TRIAL;
      end
      ST_DONE: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.op    = OP_CLEAR;
          state_nxt = ST_LOAD;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end
endmodule

>>> rtl/max_min_spacing_search_core.sv
// Top level: largest minimum spacing search over a loaded point set.
// Loading: one point beat per cycle; a beat with last set closes the set.
// After last: insertion sort in the store (one RAM read port), then span setup and
// a binary search of up to 30 trials, each a greedy scan over the sorted points.
// Input is not ready from the last beat until the result beat is taken.
// Synchronous active-low reset clears count, overflow, controller and sets place_count to 2.
module max_min_spacing_search_core #(
  parameter int MAX_POINTS = 1024
) (
  input  logic                      clk,
  input  logic                      rst_n,
  mmss_in_if.sink                   in_ch,
  mmss_out_if.source                out_ch,
  input  logic                      cfg_we,
  input  logic [mmss_pkg::PC_W-1:0] cfg_wdata
);
  import mmss_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  mmss_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_last   (in_ch.last),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  mmss_dp #(.MAX_POINTS(MAX_POINTS)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .position  (in_ch.position),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .best_gap  (out_ch.best_gap),
    .overflow  (out_ch.overflow)
  );
endmodule
